// ===== src/cef_pkg.sv =====
// Shared types and constants for the curve extremum finder.
// Used by cef_core, cef_outq and curve_extremum_finder; depends on nothing else.
package cef_pkg;

    // Saturation value of the 9-bit plateau and extremum counters.
    localparam logic [8:0] SAT9 = 9'd511;

    // Reset value of the merge distance register.
    localparam logic [8:0] MERGE_RESET = 9'd3;

    // One sample causes at most this many results.
    localparam int MAX_RESULTS = 3;

    // Result queue depth and pointer width.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_FIND_MAXIMA    = 2'd0,
        CFG_START_INDEX    = 2'd1,
        CFG_MERGE_DISTANCE = 2'd2
    } t_cfg_idx;

    // Configuration register contents.
    typedef struct packed {
        logic       find_maxima;
        logic [8:0] start_index;
        logic [8:0] merge_distance;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic [8:0] position;
        logic       is_summary;
        logic [8:0] total_count;
        logic       last;
    } t_result;

    // The results caused by one sample, in delivery order, with a valid bit each.
    typedef struct packed {
        logic [MAX_RESULTS-1:0]          valid;
        t_result [MAX_RESULTS-1:0]       slot;
    } t_result_set;

endpackage

// ===== src/curve_extremum_finder.sv =====
// Top level of the curve extremum finder: configuration registers, detection
// core and result queue. Depends on cef_pkg, cef_core and cef_outq.
//
// Usage: curve samples arrive on the input channel (i_in_valid / o_in_ready),
// one per transfer, with i_end_of_curve set on the last sample of a curve.
// Results leave on the output channel (o_out_valid / i_out_ready): one per
// extremum found, then a summary carrying the extremum count when the curve
// ends; o_last marks the final result caused by one sample.
// Configuration is written through i_cfg_wr_en / i_cfg_index / i_cfg_data
// while the block is idle, and takes effect on the next sample.
// Each sample's results are written into the result queue and leave it in order.
// Throughput: a sample is taken whenever the result queue (four entries) has
// room for the three results one sample can cause, one sample per cycle while
// it has; the output delivers one result per cycle while i_out_ready is high.
// Reset: synchronous and active low; clears the stream state, the queue and
// the configuration (minima, start index 0, merge distance 3).
// Stall: when the receiver holds i_out_ready low the queue fills and
// o_in_ready drops; nothing is lost.
module curve_extremum_finder #(
    parameter int MAX_LEN = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_index,
    input  logic [8:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_sample,
    input  logic               i_end_of_curve,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [8:0]         o_position,
    output logic               o_is_summary,
    output logic [8:0]         o_total_count,
    output logic               o_last
);

    cef_pkg::t_cfg        r_cfg, n_cfg;
    cef_pkg::t_result_set results;
    cef_pkg::t_result     out_result;
    logic                 space;
    logic                 accept;

    // Configuration register writes.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (cef_pkg::t_cfg_idx'(i_cfg_index))
                cef_pkg::CFG_FIND_MAXIMA:    n_cfg.find_maxima    = i_cfg_data[0];
                cef_pkg::CFG_START_INDEX:    n_cfg.start_index    = i_cfg_data;
                cef_pkg::CFG_MERGE_DISTANCE: n_cfg.merge_distance = i_cfg_data;
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.find_maxima    <= 1'b0;
            r_cfg.start_index    <= '0;
            r_cfg.merge_distance <= cef_pkg::MERGE_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Input transfer.
    assign o_in_ready = space;
    assign accept     = i_in_valid && space;

    cef_core #(
        .MAX_LEN (MAX_LEN)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_sample       (i_sample),
        .i_end_of_curve (i_end_of_curve),
        .i_cfg          (r_cfg),
        .o_results      (results)
    );

    cef_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_results (results),
        .o_space   (space),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_result  (out_result)
    );

    // Result fields.
    assign o_position    = out_result.position;
    assign o_is_summary  = out_result.is_summary;
    assign o_total_count = out_result.total_count;
    assign o_last        = out_result.last;

endmodule

// ===== src/cef_core.sv =====
// Detection core of the curve extremum finder: stream state and per-sample logic.
// Depends on cef_pkg for the configuration and result types.
module cef_core #(
    parameter int MAX_LEN = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic signed [15:0]   i_sample,
    input  logic                 i_end_of_curve,
    input  cef_pkg::t_cfg        i_cfg,
    output cef_pkg::t_result_set o_results
);

    // Highest index the curve may reach.
    localparam int          IdxLimitInt = ((MAX_LEN - 1) > 511) ? 511 : (MAX_LEN - 1);
    localparam logic [8:0]  IDX_LIMIT   = 9'(IdxLimitInt);

    logic signed [15:0] r_prev_sample, n_prev_sample;
    logic               r_have_prev,   n_have_prev;
    logic [8:0]         r_cur_index,   n_cur_index;
    logic [8:0]         r_plateau,     n_plateau;
    logic [8:0]         r_pend_pos,    n_pend_pos;
    logic               r_pend_valid,  n_pend_valid;
    logic [8:0]         r_count,       n_count;

    logic signed [16:0] diff;
    logic               toward;
    logic               away;
    logic signed [10:0] pos_raw;
    logic [8:0]         pos;
    logic signed [10:0] pos_gap;
    logic [9:0]         mid_sum;
    cef_pkg::t_result_set results;

    // Next stream state and the results caused by the accepted sample.
    always_comb begin
        n_prev_sample = r_prev_sample;
        n_have_prev   = r_have_prev;
        n_cur_index   = r_cur_index;
        n_plateau     = r_plateau;
        n_pend_pos    = r_pend_pos;
        n_pend_valid  = r_pend_valid;
        n_count       = r_count;
        results       = '0;

        diff    = 17'(i_sample) - 17'(r_prev_sample);
        toward  = i_cfg.find_maxima ? (diff > 17'sd0) : (diff < 17'sd0);
        away    = i_cfg.find_maxima ? (diff < 17'sd0) : (diff > 17'sd0);
        pos_raw = '0;
        pos     = '0;
        pos_gap = '0;
        mid_sum = '0;

        if (i_accept) begin
            if (!r_have_prev) begin
                // First sample of a curve: load the start index, no comparison.
                n_cur_index = (i_cfg.start_index > IDX_LIMIT) ? IDX_LIMIT
                                                              : i_cfg.start_index;
                n_have_prev = 1'b1;
                n_plateau   = '0;
            end else begin
                if (r_cur_index < IDX_LIMIT) begin
                    n_cur_index = r_cur_index + 9'd1;
                end

                // Extremum lies at the middle of the plateau, clamped at zero.
                pos_raw = $signed({2'b00, n_cur_index}) - 11'sd1
                        - $signed({3'b000, r_plateau[8:1]});
                pos     = (pos_raw < 11'sd0) ? 9'd0 : pos_raw[8:0];
                pos_gap = $signed({2'b00, pos}) - $signed({2'b00, r_pend_pos});
                mid_sum = {1'b0, r_pend_pos} + {1'b0, pos};

                if (toward) begin
                    n_plateau = 9'd1;
                end else if (diff == 17'sd0 && r_plateau != 9'd0) begin
                    if (r_plateau < cef_pkg::SAT9) begin
                        n_plateau = r_plateau + 9'd1;
                    end
                end else if (away && r_plateau != 9'd0) begin
                    n_plateau = '0;
                    if (r_pend_valid &&
                        pos_gap < $signed({2'b00, i_cfg.merge_distance})) begin
                        // Close to the pending one: merge at the floored midpoint.
                        n_pend_pos = mid_sum[9:1];
                    end else begin
                        if (r_pend_valid) begin
                            results.valid[0]            = 1'b1;
                            results.slot[0].position    = r_pend_pos;
                            results.slot[0].last        = !i_end_of_curve;
                            if (r_count < cef_pkg::SAT9) begin
                                n_count = r_count + 9'd1;
                            end
                        end
                        n_pend_pos   = pos;
                        n_pend_valid = 1'b1;
                    end
                end
            end
            n_prev_sample = i_sample;

            // End of curve: flush the pending extremum, then the summary.
            if (i_end_of_curve) begin
                if (n_pend_valid) begin
                    results.valid[1]         = 1'b1;
                    results.slot[1].position = n_pend_pos;
                    if (n_count < cef_pkg::SAT9) begin
                        n_count = n_count + 9'd1;
                    end
                end
                results.valid[2]            = 1'b1;
                results.slot[2].is_summary  = 1'b1;
                results.slot[2].total_count = n_count;
                results.slot[2].last        = 1'b1;

                n_have_prev  = 1'b0;
                n_cur_index  = '0;
                n_plateau    = '0;
                n_pend_pos   = '0;
                n_pend_valid = 1'b0;
                n_count      = '0;
            end
        end
    end

    assign o_results = results;

    // Stream state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_sample <= '0;
            r_have_prev   <= 1'b0;
            r_cur_index   <= '0;
            r_plateau     <= '0;
            r_pend_pos    <= '0;
            r_pend_valid  <= 1'b0;
            r_count       <= '0;
        end else begin
            r_prev_sample <= n_prev_sample;
            r_have_prev   <= n_have_prev;
            r_cur_index   <= n_cur_index;
            r_plateau     <= n_plateau;
            r_pend_pos    <= n_pend_pos;
            r_pend_valid  <= n_pend_valid;
            r_count       <= n_count;
        end
    end

endmodule

// ===== src/cef_outq.sv =====
// Result queue of the curve extremum finder: takes up to three results per
// cycle and delivers one per transfer. Depends on cef_pkg for the result types.
module cef_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cef_pkg::t_result_set i_results,
    output logic                 o_space,
    output logic                 o_valid,
    input  logic                 i_ready,
    output cef_pkg::t_result     o_result
);

    localparam int CNT_W = cef_pkg::QPTR_W + 1;

    cef_pkg::t_result r_entry [cef_pkg::QDEPTH];
    logic [cef_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [cef_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]           r_count,  n_count;

    logic                       pop;
    logic [CNT_W-1:0]           push_n;
    logic [cef_pkg::QPTR_W-1:0] wr_addr [cef_pkg::MAX_RESULTS];

    // Room for a full set of results from the next sample.
    assign o_space  = (r_count <= CNT_W'(cef_pkg::QDEPTH - cef_pkg::MAX_RESULTS));
    assign o_valid  = (r_count != '0);
    assign o_result = r_entry[r_rd_ptr];
    assign pop      = o_valid && i_ready;

    // Pack the valid results onto consecutive entries.
    always_comb begin
        push_n = '0;
        for (int k = 0; k < cef_pkg::MAX_RESULTS; k++) begin
            wr_addr[k] = r_wr_ptr + push_n[cef_pkg::QPTR_W-1:0];
            push_n     = push_n + CNT_W'(i_results.valid[k]);
        end
        n_wr_ptr = r_wr_ptr + push_n[cef_pkg::QPTR_W-1:0];
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + push_n - CNT_W'(pop);
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < cef_pkg::MAX_RESULTS; k++) begin
            if (i_results.valid[k]) begin
                r_entry[wr_addr[k]] <= i_results.slot[k];
            end
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for curve_extremum_finder: random curves and stalls on both channels.
// A per-sample predictor in this file computes the expected results. Depends on cef_pkg and
// the curve_extremum_finder RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CURVE_LEN = 512;
    localparam int IDX_LIMIT = (CURVE_LEN - 1 > 511) ? 511 : CURVE_LEN - 1;
    localparam int COUNT_SAT = int'(cef_pkg::SAT9);
    localparam int HALF_PERIOD = 10;
    localparam int MAX_GAP = 18;
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_HOLD = 200;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int REPORT_LIMIT = 10;
    // Index with no register behind it; writes to it must change nothing.
    localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;

    typedef struct {
        logic signed [15:0] value;
        logic               eoc;
    } t_sample_item;

    typedef enum {SHAPE_WALK, SHAPE_ZIGZAG, SHAPE_NOISE, SHAPE_FLAT} t_curve_shape;

    // Clock, reset and block ports; every input starts at a known value.
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [1:0]         i_cfg_index = '0;
    logic [8:0]         i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [15:0] i_sample = '0;
    logic               i_end_of_curve = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [8:0]         o_position;
    logic               o_is_summary;
    logic [8:0]         o_total_count;
    logic               o_last;

    curve_extremum_finder #(.MAX_LEN(CURVE_LEN)) uut (.*);

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Shadow copy of the configuration registers.
    bit cfg_maxima = 1'b0;
    int cfg_start = 0;
    int cfg_merge = int'(cef_pkg::MERGE_RESET);

    // Shadow copy of the detector state.
    int prev_sample = 0;
    bit have_prev = 1'b0;
    int cur_index = 0;
    int plateau = 0;
    int pend_pos = 0;
    bit pend_valid = 1'b0;
    int found_count = 0;

    t_sample_item         pending_samples[$];
    cef_pkg::t_result     expected_results[$];

    // Handshake bookkeeping shared between the posedge and negedge processes.
    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    int drv_gap = 0;
    int rcv_gap = 0;
    bit drv_calm = 1'b0;
    bit rcv_calm = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;
    int mismatch_count = 0;
    int results_seen = 0;
    int cycle_count = 0;
    t_sample_item drv_item;
    cef_pkg::t_result got_result;
    cef_pkg::t_result want_result;

    function automatic cef_pkg::t_result make_result(int pos, bit summary, int cnt);
        cef_pkg::t_result r;
        r.position = pos[8:0];
        r.is_summary = summary;
        r.total_count = cnt[8:0];
        r.last = 1'b0;
        return r;
    endfunction

    // Advance the detector by one sample and queue the results it causes.
    function automatic void predict_results(logic signed [15:0] smp, logic eoc);
        int s;
        int d;
        int pos;
        bit toward;
        bit away;
        cef_pkg::t_result found[$];
        cef_pkg::t_result r;
        s = smp;
        if (!have_prev) begin
            cur_index = (cfg_start > IDX_LIMIT) ? IDX_LIMIT : cfg_start;
            have_prev = 1'b1;
            plateau = 0;
        end else begin
            d = s - prev_sample;
            if (cur_index < IDX_LIMIT) cur_index++;
            toward = cfg_maxima ? (d > 0) : (d < 0);
            away = cfg_maxima ? (d < 0) : (d > 0);
            if (toward) begin
                plateau = 1;
            end else if (d == 0 && plateau >= 1) begin
                if (plateau < COUNT_SAT) plateau++;
            end else if (away && plateau >= 1) begin
                // The extremum sits in the middle of the plateau, rounded toward its start.
                pos = cur_index - 1 - plateau / 2;
                if (pos < 0) pos = 0;
                plateau = 0;
                if (pend_valid && (pos - pend_pos) < cfg_merge) begin
                    pend_pos = (pend_pos + pos) >> 1;
                end else begin
                    if (pend_valid) begin
                        found.push_back(make_result(pend_pos, 1'b0, 0));
                        if (found_count < COUNT_SAT) found_count++;
                    end
                    pend_pos = pos;
                    pend_valid = 1'b1;
                end
            end
        end
        prev_sample = s;

        // End of curve: flush the pending extremum, report the count, clear the stream.
        if (eoc) begin
            if (pend_valid) begin
                found.push_back(make_result(pend_pos, 1'b0, 0));
                if (found_count < COUNT_SAT) found_count++;
            end
            found.push_back(make_result(0, 1'b1, found_count));
            have_prev = 1'b0;
            cur_index = 0;
            plateau = 0;
            pend_pos = 0;
            pend_valid = 1'b0;
            found_count = 0;
        end

        if (found.size() > 0) begin
            r = found.pop_back();
            r.last = 1'b1;
            found.push_back(r);
        end
        foreach (found[k]) expected_results.push_back(found[k]);
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("result %0d: %s expected %0d, got %0d", results_seen, name, want, got);
        end
    endfunction

    // Input side: predict on every transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predict_results(i_sample, i_end_of_curve);
            in_taken = 1'b1;
        end
    end

    // Input driver: after each transfer wait the drawn gap, then offer the next sample.
    always @(negedge i_clk) begin
        if (i_rst_n && (in_taken || !i_in_valid)) begin
            in_taken = 1'b0;
            if (hold_left > 0) drv_gap = 0;
            if (drv_gap > 0) begin
                drv_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
                drv_item = pending_samples.pop_front();
                i_sample <= drv_item.value;
                i_end_of_curve <= drv_item.eoc;
                i_in_valid <= 1'b1;
                if ($urandom_range(0, 23) == 0) drv_calm = !drv_calm;
                drv_gap = drv_calm ? 0 : $urandom_range(0, MAX_GAP);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output side: compare every transfer with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            out_taken = 1'b1;
            results_seen++;
            got_result = make_result(o_position, o_is_summary, o_total_count);
            got_result.last = o_last;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("result %0d: none expected, got position %0d summary %0b count %0d",
                             results_seen, o_position, o_is_summary, o_total_count);
            end else begin
                want_result = expected_results.pop_front();
                check_field("position", want_result.position, got_result.position);
                check_field("is_summary", want_result.is_summary, got_result.is_summary);
                check_field("total_count", want_result.total_count, got_result.total_count);
                check_field("last", want_result.last, got_result.last);
            end
        end
    end

    // Output ready: a drawn gap after each transfer, forced low during the long hold.
    always @(negedge i_clk) begin
        if (out_taken) begin
            out_taken = 1'b0;
            if ($urandom_range(0, 23) == 0) rcv_calm = !rcv_calm;
            rcv_gap = rcv_calm ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (!i_rst_n || hold_left > 0) begin
            i_out_ready <= 1'b0;
        end else if (rcv_gap > 0) begin
            rcv_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // One long receiver hold, counted here once requested.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
        end else if (hold_req && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [8:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        case (idx)
            cef_pkg::CFG_FIND_MAXIMA:    cfg_maxima = data[0];
            cef_pkg::CFG_START_INDEX:    cfg_start = data;
            cef_pkg::CFG_MERGE_DISTANCE: cfg_merge = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(int maxima, int start, int merge);
        write_reg(cef_pkg::CFG_FIND_MAXIMA, maxima[8:0]);
        write_reg(cef_pkg::CFG_START_INDEX, start[8:0]);
        write_reg(cef_pkg::CFG_MERGE_DISTANCE, merge[8:0]);
    endtask

    task automatic push_sample(int value, bit eoc);
        t_sample_item it;
        it.value = value[15:0];
        it.eoc = eoc;
        pending_samples.push_back(it);
    endtask

    // Queue one curve of the given shape; the last sample closes it when asked.
    task automatic add_curve(int len, t_curve_shape shape, bit close);
        int v;
        int base;
        int amp;
        int r;
        base = $urandom_range(0, 64535) - 32768;
        amp = $urandom_range(1, 1000);
        v = base;
        for (int k = 0; k < len; k++) begin
            case (shape)
                SHAPE_WALK: begin
                    r = $urandom_range(0, 9);
                    if (r >= 7) v -= $urandom_range(1, 4);
                    else if (r >= 4) v += $urandom_range(1, 4);
                end
                SHAPE_ZIGZAG: v = base + ((k % 2 == 1) ? amp : 0);
                SHAPE_NOISE:  v = $urandom_range(0, 65535) - 32768;
                SHAPE_FLAT:   v = base + ((k == 0 || k == len - 1) ? amp : 0);
                default: ;
            endcase
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            push_sample(v, close && (k == len - 1));
        end
    endtask

    // Mostly well-formed curves with random content, some noise, the last one maybe left open.
    task automatic fill_random(int count);
        int n;
        int len;
        int r;
        t_curve_shape shape;
        n = 0;
        while (n < count) begin
            len = $urandom_range(1, 24);
            r = $urandom_range(0, 9);
            shape = (r < 5) ? SHAPE_WALK : (r < 8) ? SHAPE_ZIGZAG : SHAPE_NOISE;
            add_curve(len, shape, (n + len < count) ? 1'b1 : 1'(($urandom_range(0, 1))));
            n += len;
        end
    endtask

    // Wait until every queued sample is taken and every expected result has arrived.
    task automatic wait_idle();
        while (pending_samples.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Test sequence.
    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: a single-sample curve, then a curve ending on a detection.
        push_sample(-32768, 1'b1);
        push_sample(0, 1'b0);
        push_sample(-5, 1'b0);
        push_sample(0, 1'b0);
        push_sample(0, 1'b0);
        push_sample(-9, 1'b0);
        push_sample(0, 1'b0);
        push_sample(0, 1'b0);
        push_sample(0, 1'b0);
        push_sample(0, 1'b0);
        push_sample(-3, 1'b0);
        push_sample(5, 1'b1);
        wait_idle();

        // Maxima at the saturated index with merging off, full-scale samples.
        set_config(1, 511, 0);
        push_sample(-32768, 1'b0);
        push_sample(32767, 1'b0);
        push_sample(32767, 1'b0);
        push_sample(-32768, 1'b0);
        push_sample(0, 1'b0);
        push_sample(32767, 1'b0);
        push_sample(-1, 1'b1);
        wait_idle();
        write_reg(CFG_SPARE_INDEX, 9'h1AA);

        // Random phases over a spread of settings, extremes included.
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: set_config(1, 0, 1);
                1: set_config(0, 511, 511);
                2: set_config(1, 500, 3);
                3: set_config(0, $urandom_range(0, 511), $urandom_range(1, 20));
                4: set_config(1, $urandom_range(0, 511), 0);
                5: set_config(0, 0, 2);
                default: set_config($urandom_range(0, 1), $urandom_range(0, 511),
                                    $urandom_range(0, 511));
            endcase
            fill_random(25);
            wait_idle();
        end

        // A long flat stretch between two higher ends.
        set_config(0, 0, 3);
        add_curve(24, SHAPE_FLAT, 1'b1);
        wait_idle();

        // A dense zigzag under a long receiver hold.
        set_config(1, 0, 0);
        hold_req = 1'b1;
        add_curve(24, SHAPE_ZIGZAG, 1'b1);
        wait_idle();

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
